/* sv/v3a_pkg.sv */
// Shared constants, types and saturation helper for the three-component vector ALU.
package v3a_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int TOL_WIDTH   = DATA_WIDTH - 1;
  localparam int SQ_WIDTH    = 2 * DATA_WIDTH;
  localparam int ROOT_WIDTH  = DATA_WIDTH;
  localparam int QUO_WIDTH   = DATA_WIDTH + FRAC_BITS;
  localparam int OPND_WIDTH  = DATA_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * OPND_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 2;
  localparam int SQRT_STAGES = ROOT_WIDTH;
  localparam int DIV_STAGES  = QUO_WIDTH;

  localparam logic [3:0] OP_ADD       = 4'd0;
  localparam logic [3:0] OP_SUB       = 4'd1;
  localparam logic [3:0] OP_SCALE     = 4'd2;
  localparam logic [3:0] OP_DIV       = 4'd3;
  localparam logic [3:0] OP_DOT       = 4'd4;
  localparam logic [3:0] OP_CROSS     = 4'd5;
  localparam logic [3:0] OP_NORM      = 4'd6;
  localparam logic [3:0] OP_NORMALIZE = 4'd7;
  localparam logic [3:0] OP_DIST      = 4'd8;
  localparam logic [3:0] OP_EQUAL     = 4'd9;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic  ovf;
    word_t val;
  } sat_t;

  // clamp a wide signed value into one word
  function automatic sat_t sat_word(input logic signed [SUM_WIDTH-1:0] v);
    sat_t r;
    logic [SUM_WIDTH-DATA_WIDTH:0] top;
    top   = v[SUM_WIDTH-1:DATA_WIDTH-1];
    r.ovf = !((&top) || (~|top));
    if (r.ovf) begin
      r.val = v[SUM_WIDTH-1] ? WORD_MIN : WORD_MAX;
    end else begin
      r.val = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/v3a_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module v3a_isqrt import v3a_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQ_WIDTH-1:0]   radicand,
  output logic [ROOT_WIDTH-1:0] root
);

  logic [SQ_WIDTH-1:0] rem [1:SQRT_STAGES];
  logic [SQ_WIDTH-1:0] acc [1:SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    localparam logic [SQ_WIDTH-1:0] BIT = SQ_WIDTH'(1) << (SQ_WIDTH - 2 - 2 * i);
    logic [SQ_WIDTH-1:0] rin;
    logic [SQ_WIDTH-1:0] ain;
    logic [SQ_WIDTH-1:0] trial;

    if (i == 0) begin : g_first
      assign rin = radicand;
      assign ain = '0;
    end else begin : g_rest
      assign rin = rem[i];
      assign ain = acc[i];
    end

    assign trial = ain + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          rem[i+1] <= rin - trial;
          acc[i+1] <= (ain >> 1) + BIT;
        end else begin
          rem[i+1] <= rin;
          acc[i+1] <= ain >> 1;
        end
      end
    end
  end

  assign root = acc[SQRT_STAGES][ROOT_WIDTH-1:0];

endmodule

/* sv/v3a_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
module v3a_div import v3a_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [QUO_WIDTH-1:0]  dividend,
  input  logic [ROOT_WIDTH-1:0] divisor,
  output logic [QUO_WIDTH-1:0]  quot
);

  logic [QUO_WIDTH-1:0]  num [1:DIV_STAGES];
  logic [ROOT_WIDTH-1:0] rem [1:DIV_STAGES];
  logic [QUO_WIDTH-1:0]  quo [1:DIV_STAGES];
  logic [ROOT_WIDTH-1:0] den [1:DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [QUO_WIDTH-1:0]  nin;
    logic [ROOT_WIDTH-1:0] rin;
    logic [QUO_WIDTH-1:0]  qin;
    logic [ROOT_WIDTH-1:0] din;
    logic [ROOT_WIDTH:0]   trial;
    logic [ROOT_WIDTH:0]   diff;
    logic                  ge;

    if (i == 0) begin : g_first
      assign nin = dividend;
      assign rin = '0;
      assign qin = '0;
      assign din = divisor;
    end else begin : g_rest
      assign nin = num[i];
      assign rin = rem[i];
      assign qin = quo[i];
      assign din = den[i];
    end

    assign trial = {rin, nin[QUO_WIDTH-1]};
    assign diff  = trial - {1'b0, din};
    assign ge    = trial >= {1'b0, din};

    always_ff @(posedge clk) begin
      if (en) begin
        num[i+1] <= nin << 1;
        den[i+1] <= din;
        quo[i+1] <= {qin[QUO_WIDTH-2:0], ge};
        rem[i+1] <= ge ? diff[ROOT_WIDTH-1:0] : trial[ROOT_WIDTH-1:0];
      end
    end
  end

  assign quot = quo[DIV_STAGES];

endmodule

/* sv/vector3_alu_top.sv */
// Top level of the three-component vector ALU: front stages, root and divide pipelines.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata (equal_tolerance_sq)
//  input    | in_valid / in_ready       | operation, a_x..a_z, b_x..b_z, scalar_in
//  output   | out_valid / out_ready     | res_x..res_z, res_scalar, equal_flag, status
//
// One word enters per cycle while the output is not stalled. It passes four front
// stages, the 32-stage square root, one divisor select stage, the 48-stage divider
// and the output register before out_valid.
// rst is synchronous and clears every valid bit and the tolerance register (to 1).
// A stall on the output freezes the whole pipeline; in_ready drops only then.
module vector3_alu_top import v3a_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // input words
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [3:0]             operation,
  input  logic signed [DATA_WIDTH-1:0] a_x,
  input  logic signed [DATA_WIDTH-1:0] a_y,
  input  logic signed [DATA_WIDTH-1:0] a_z,
  input  logic signed [DATA_WIDTH-1:0] b_x,
  input  logic signed [DATA_WIDTH-1:0] b_y,
  input  logic signed [DATA_WIDTH-1:0] b_z,
  input  logic signed [DATA_WIDTH-1:0] scalar_in,
  // result words
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [DATA_WIDTH-1:0] res_x,
  output logic signed [DATA_WIDTH-1:0] res_y,
  output logic signed [DATA_WIDTH-1:0] res_z,
  output logic signed [DATA_WIDTH-1:0] res_scalar,
  output logic                   equal_flag,
  output logic [1:0]             status
);

  localparam logic REG_TOL = 1'b0;

  // side data travelling beside the square root
  typedef struct packed {
    logic [3:0]      op;
    word_t [2:0]     a;
    word_t           s;
    word_t [2:0]     vec;
    word_t           dot;
    logic            ovf;
    logic            eq;
  } sq_side_t;

  // side data travelling beside the dividers
  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      a_pos;
    logic [2:0]      a_neg;
    logic [2:0]      neg;
    word_t [2:0]     vec;
    word_t           scl;
    logic            ovf;
    logic            dz;
    logic            eq;
  } dv_side_t;

  // ---------------------------------------------------------------- config port
  logic [TOL_WIDTH-1:0] tol;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOL) ? {1'b0, tol} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_WIDTH'(1);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOL)) begin
      tol <= pwdata[TOL_WIDTH-1:0];
    end
  end

  // ---------------------------------------------------------------- flow control
  // Everything advances together whenever the output register can move on.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic v1, v2, v3;
  logic sq_vld [0:SQRT_STAGES];
  logic dv_vld [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= SQRT_STAGES; k++) sq_vld[k] <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) dv_vld[k] <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      sq_vld[0] <= v3;
      for (int k = 1; k <= SQRT_STAGES; k++) sq_vld[k] <= sq_vld[k-1];
      dv_vld[0] <= sq_vld[SQRT_STAGES];
      for (int k = 1; k <= DIV_STAGES; k++) dv_vld[k] <= dv_vld[k-1];
      out_valid <= dv_vld[DIV_STAGES];
    end
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic [3:0] op1;
  word_t      a1 [0:2];
  word_t      b1 [0:2];
  word_t      s1;

  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= operation;
      a1[0] <= a_x;
      a1[1] <= a_y;
      a1[2] <= a_z;
      b1[0] <= b_x;
      b1[1] <= b_y;
      b1[2] <= b_z;
      s1    <= scalar_in;
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  // Six multipliers; the operand pairs depend on the operation.
  logic signed [OPND_WIDTH-1:0] d1    [0:2];
  logic signed [OPND_WIDTH-1:0] as1   [0:2];
  logic signed [OPND_WIDTH-1:0] opa   [0:5];
  logic signed [OPND_WIDTH-1:0] opb   [0:5];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1[i]  = OPND_WIDTH'(b1[i]) - OPND_WIDTH'(a1[i]);
      as1[i] = (op1 == OP_SUB) ? OPND_WIDTH'(a1[i]) - OPND_WIDTH'(b1[i])
                               : OPND_WIDTH'(a1[i]) + OPND_WIDTH'(b1[i]);
    end
    for (int k = 0; k < 6; k++) begin
      opa[k] = '0;
      opb[k] = '0;
    end
    case (op1) inside
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = OPND_WIDTH'(a1[i]);
          opb[i] = OPND_WIDTH'(s1);
        end
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = OPND_WIDTH'(a1[i]);
          opb[i] = OPND_WIDTH'(b1[i]);
        end
      end
      OP_CROSS: begin
        opa[0] = OPND_WIDTH'(a1[1]); opb[0] = OPND_WIDTH'(b1[2]);
        opa[3] = OPND_WIDTH'(a1[2]); opb[3] = OPND_WIDTH'(b1[1]);
        opa[1] = OPND_WIDTH'(a1[2]); opb[1] = OPND_WIDTH'(b1[0]);
        opa[4] = OPND_WIDTH'(a1[0]); opb[4] = OPND_WIDTH'(b1[2]);
        opa[2] = OPND_WIDTH'(a1[0]); opb[2] = OPND_WIDTH'(b1[1]);
        opa[5] = OPND_WIDTH'(a1[1]); opb[5] = OPND_WIDTH'(b1[0]);
      end
      OP_NORM, OP_NORMALIZE: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = OPND_WIDTH'(a1[i]);
          opb[i] = OPND_WIDTH'(a1[i]);
        end
      end
      OP_DIST, OP_EQUAL: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = d1[i];
          opb[i] = d1[i];
        end
      end
      default: begin
      end
    endcase
  end

  logic [3:0]                   op2;
  word_t                        a2   [0:2];
  word_t                        s2;
  logic signed [PROD_WIDTH-1:0] prod [0:5];
  logic signed [OPND_WIDTH-1:0] as2  [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      op2 <= op1;
      s2  <= s1;
      for (int i = 0; i < 3; i++) begin
        a2[i]  <= a1[i];
        as2[i] <= as1[i];
      end
      for (int k = 0; k < 6; k++) prod[k] <= opa[k] * opb[k];
    end
  end

  // ---------------------------------------------------------------- stage 3: sums
  logic [3:0]                   op3;
  word_t                        a3  [0:2];
  word_t                        s3;
  logic signed [OPND_WIDTH-1:0] as3 [0:2];
  logic signed [SUM_WIDTH-1:0]  c3  [0:2];
  logic signed [SUM_WIDTH-1:0]  sum3;

  always_ff @(posedge clk) begin
    if (en) begin
      op3  <= op2;
      s3   <= s2;
      sum3 <= SUM_WIDTH'(prod[0]) + SUM_WIDTH'(prod[1]) + SUM_WIDTH'(prod[2]);
      for (int i = 0; i < 3; i++) begin
        a3[i]  <= a2[i];
        as3[i] <= as2[i];
        c3[i]  <= SUM_WIDTH'(prod[i]) - SUM_WIDTH'(prod[i+3]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 4: round, clamp
  sat_t                 sa [0:2];
  sat_t                 sm [0:2];
  sat_t                 sd;
  sq_side_t             s4_next;
  logic [SQ_WIDTH-1:0]  sq_next;

  always_comb begin
    s4_next     = '0;
    s4_next.op  = op3;
    s4_next.s   = s3;
    sd          = sat_word(sum3 >>> FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      s4_next.a[i] = a3[i];
      sa[i]        = sat_word(SUM_WIDTH'(as3[i]));
      sm[i]        = sat_word(c3[i] >>> FRAC_BITS);
    end
    // sum of squares tops out at all ones
    sq_next    = (|sum3[SUM_WIDTH-1:SQ_WIDTH]) ? '1 : sum3[SQ_WIDTH-1:0];
    s4_next.eq = (op3 == OP_EQUAL) && (sq_next < {tol, {FRAC_BITS{1'b0}}});
    case (op3) inside
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) s4_next.vec[i] = sa[i].val;
        s4_next.ovf = sa[0].ovf || sa[1].ovf || sa[2].ovf;
      end
      OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 3; i++) s4_next.vec[i] = sm[i].val;
        s4_next.ovf = sm[0].ovf || sm[1].ovf || sm[2].ovf;
      end
      OP_DOT: begin
        s4_next.dot = sd.val;
        s4_next.ovf = sd.ovf;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- square root
  sq_side_t            sq_line [0:SQRT_STAGES];
  logic [SQ_WIDTH-1:0] sq_in;
  logic [ROOT_WIDTH-1:0] root;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_line[0] <= s4_next;
      sq_in      <= sq_next;
      for (int k = 1; k <= SQRT_STAGES; k++) sq_line[k] <= sq_line[k-1];
    end
  end

  v3a_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sq_in),
    .root     (root)
  );

  // ---------------------------------------------------------------- stage 5: divisor select
  sq_side_t              sq_out;
  dv_side_t              s5_next;
  logic [ROOT_WIDTH-1:0] den_next;
  logic [QUO_WIDTH-1:0]  num_next [0:2];
  logic [ROOT_WIDTH-1:0] s_abs;
  logic [ROOT_WIDTH-1:0] a_abs    [0:2];
  logic                  root_op;

  always_comb begin
    sq_out  = sq_line[SQRT_STAGES];
    root_op = (sq_out.op == OP_NORM) || (sq_out.op == OP_DIST);
    s_abs   = sq_out.s[DATA_WIDTH-1] ? ROOT_WIDTH'(-sq_out.s) : ROOT_WIDTH'(sq_out.s);
    den_next = (sq_out.op == OP_DIV) ? s_abs : root;

    s5_next     = '0;
    s5_next.op  = sq_out.op;
    s5_next.vec = sq_out.vec;
    s5_next.eq  = sq_out.eq;
    s5_next.ovf = sq_out.ovf || (root_op && root[ROOT_WIDTH-1]);
    if (root_op) begin
      s5_next.scl = root[ROOT_WIDTH-1] ? WORD_MAX : word_t'(root);
    end else begin
      s5_next.scl = sq_out.dot;
    end
    s5_next.dz = ((sq_out.op == OP_DIV) && (sq_out.s == '0)) ||
                 ((sq_out.op == OP_NORMALIZE) && (root == '0));
    for (int i = 0; i < 3; i++) begin
      a_abs[i] = sq_out.a[i][DATA_WIDTH-1] ? ROOT_WIDTH'(-sq_out.a[i])
                                           : ROOT_WIDTH'(sq_out.a[i]);
      num_next[i]      = {a_abs[i], {FRAC_BITS{1'b0}}};
      s5_next.a_neg[i] = sq_out.a[i][DATA_WIDTH-1];
      s5_next.a_pos[i] = !sq_out.a[i][DATA_WIDTH-1] && (sq_out.a[i] != '0);
      s5_next.neg[i]   = sq_out.a[i][DATA_WIDTH-1] ^
                         ((sq_out.op == OP_DIV) && sq_out.s[DATA_WIDTH-1]);
    end
  end

  // ---------------------------------------------------------------- dividers
  dv_side_t              dv_line [0:DIV_STAGES];
  logic [ROOT_WIDTH-1:0] dv_den;
  logic [QUO_WIDTH-1:0]  dv_num  [0:2];
  logic [QUO_WIDTH-1:0]  quot    [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_line[0] <= s5_next;
      dv_den     <= den_next;
      for (int i = 0; i < 3; i++) dv_num[i] <= num_next[i];
      for (int k = 1; k <= DIV_STAGES; k++) dv_line[k] <= dv_line[k-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend (dv_num[i]),
      .divisor  (dv_den),
      .quot     (quot[i])
    );
  end

  // ---------------------------------------------------------------- final: select, status
  dv_side_t                    fin;
  logic signed [SUM_WIDTH-1:0] qs [0:2];
  sat_t                        qsat [0:2];
  word_t                       vec_next [0:2];
  word_t                       scalar_next;
  logic                        flag_next;
  logic [1:0]                  status_next;
  logic                        ovf_f;

  always_comb begin
    fin = dv_line[DIV_STAGES];
    for (int i = 0; i < 3; i++) begin
      qs[i]       = $signed(SUM_WIDTH'(quot[i]));
      if (fin.neg[i]) qs[i] = -qs[i];
      qsat[i]     = sat_word(qs[i]);
      vec_next[i] = '0;
    end
    scalar_next = '0;
    flag_next   = 1'b0;
    ovf_f       = 1'b0;
    case (fin.op) inside
      OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 3; i++) vec_next[i] = fin.vec[i];
        ovf_f = fin.ovf;
      end
      OP_DOT, OP_NORM, OP_DIST: begin
        scalar_next = fin.scl;
        ovf_f       = fin.ovf;
      end
      OP_DIV, OP_NORMALIZE: begin
        if (fin.dz) begin
          // zero divisor: a divide pushes each component to the rail of its sign; a normalize gives zero
          if (fin.op == OP_DIV) begin
            for (int i = 0; i < 3; i++) begin
              vec_next[i] = fin.a_pos[i] ? WORD_MAX : (fin.a_neg[i] ? WORD_MIN : '0);
            end
          end
        end else begin
          for (int i = 0; i < 3; i++) vec_next[i] = qsat[i].val;
          ovf_f = qsat[0].ovf || qsat[1].ovf || qsat[2].ovf;
        end
      end
      OP_EQUAL: begin
        flag_next = fin.eq;
      end
      default: begin
      end
    endcase
    if (fin.dz) begin
      status_next = ST_DZ;
    end else if (ovf_f) begin
      status_next = ST_OVF;
    end else begin
      status_next = ST_OK;
    end
  end

  // output register: hold while stalled, advance otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      res_x      <= vec_next[0];
      res_y      <= vec_next[1];
      res_z      <= vec_next[2];
      res_scalar <= scalar_next;
      equal_flag <= flag_next;
      status     <= status_next;
    end
  end

endmodule

/* sv/v3a_checker.sv */
// Port-level checks for the vector ALU, bound to the top level.
module v3a_checker import v3a_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [DATA_WIDTH-1:0] res_x,
  input logic signed [DATA_WIDTH-1:0] res_scalar,
  input logic                   equal_flag,
  input logic [1:0]             status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_x) && $stable(status))
    else $error("stalled result word changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_DZ || status == ST_OVF))
    else $error("undefined status code");

  a_equal_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && equal_flag |-> status == ST_OK && res_scalar == '0 && res_x == '0)
    else $error("equal flag with other results set");

  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DZ |-> res_scalar == '0 && !equal_flag)
    else $error("divide by zero with scalar result set");

endmodule

bind vector3_alu_top v3a_checker u_chk (.*);
